FILE: hw/rtl/rect_polar_converter_defines.svh
// Assertion macros used by the rectangular/polar converter top level.
`ifndef RECT_POLAR_CONVERTER_DEFINES_SVH
`define RECT_POLAR_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define RPC_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define RPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/rpc_pkg.sv
// Shared constants, types and elaboration helpers of the rectangular/polar converter.
package rpc_pkg;

  // Fraction bits carried by the CORDIC coordinates.
  localparam int GUARD = 24;
  // Headroom bits above sign and integer part of the coordinates.
  localparam int DP_EXTRA = 3;
  // Internal angles are 32-bit turn units held with two bits of headroom.
  localparam int Z_WIDTH = 34;

  // Operation codes on the request selector.
  localparam logic [1:0] OP_RECT  = 2'd0;
  localparam logic [1:0] OP_POLAR = 2'd1;

  // Quarter and half turn in internal angle units.
  localparam logic signed [Z_WIDTH-1:0] Z_QUARTER = Z_WIDTH'(64'd1 << 30);
  localparam logic signed [Z_WIDTH-1:0] Z_HALF    = Z_WIDTH'(64'd1 << 31);

  // atan(2^-i) in turn units, 2^32 being a full turn.
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Control bits that travel with every pipeline stage.
  typedef struct packed {
    logic valid;
    logic rect;
    logic polar;
  } ctl_t;

  // Square root (Q30) of the squared CORDIC growth in Q60, for the gain constant.
  function automatic logic [63:0] gain_root(input int stages);
    logic [63:0] p;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    int          n;
    n = (stages > 32) ? 32 : stages;
    p = 64'd1 << 60;
    for (int i = 0; i < 32; i++) begin
      if (i < n) begin
        p = p + (p >> (2 * i));
      end
    end
    v = p;
    r = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/rpc_prep.sv
// Input stages: opcode decode, operand squares, CORDIC start vector, sum of squares.
module rpc_prep #(
  parameter int DATA_WIDTH = 16,
  localparam int W = DATA_WIDTH + rpc_pkg::GUARD + rpc_pkg::DP_EXTRA,
  localparam int VW = 2 * DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [1:0]                   opcode,
  input  logic signed [DATA_WIDTH-1:0] a_in,
  input  logic signed [DATA_WIDTH-1:0] b_in,
  output rpc_pkg::ctl_t                ctl_out,
  output logic signed [DATA_WIDTH-1:0] a_out,
  output logic signed [DATA_WIDTH-1:0] b_out,
  output logic signed [W-1:0]          x_out,
  output logic signed [W-1:0]          y_out,
  output logic signed [rpc_pkg::Z_WIDTH-1:0] z_out,
  output logic [VW-1:0]                v_out
);

  localparam int ZW = rpc_pkg::Z_WIDTH;
  localparam int SH = 32 - DATA_WIDTH;

  logic signed [W-1:0]          a_ext;
  logic signed [W-1:0]          b_ext;
  logic signed [ZW-1:0]         z_pol;
  logic signed [VW-1:0]         prod_a;
  logic signed [VW-1:0]         prod_b;
  logic signed [W-1:0]          x_init;
  logic signed [W-1:0]          y_init;
  logic signed [ZW-1:0]         z_init;
  rpc_pkg::ctl_t                ctl_init;

  rpc_pkg::ctl_t                ctl1;
  logic signed [DATA_WIDTH-1:0] a1;
  logic signed [DATA_WIDTH-1:0] b1;
  logic signed [W-1:0]          x1;
  logic signed [W-1:0]          y1;
  logic signed [ZW-1:0]         z1;
  logic [VW-1:0]                sqa1;
  logic [VW-1:0]                sqb1;

  // Operands as fixed-point coordinates and as a turn-unit angle.
  assign a_ext  = {{(W - DATA_WIDTH){a_in[DATA_WIDTH-1]}}, a_in} <<< rpc_pkg::GUARD;
  assign b_ext  = {{(W - DATA_WIDTH){b_in[DATA_WIDTH-1]}}, b_in} <<< rpc_pkg::GUARD;
  assign z_pol  = {{(ZW - DATA_WIDTH){b_in[DATA_WIDTH-1]}}, b_in} <<< SH;
  assign prod_a = a_in * a_in;
  assign prod_b = b_in * b_in;

  // Decode and fold the start vector into the right half plane or the
  // quarter turns around zero.
  always_comb begin
    ctl_init.valid = in_valid;
    ctl_init.rect  = (opcode == rpc_pkg::OP_RECT);
    ctl_init.polar = (opcode == rpc_pkg::OP_POLAR);
    x_init = a_ext;
    y_init = b_ext;
    z_init = '0;
    if (ctl_init.rect) begin
      if (a_in < 0) begin
        x_init = -a_ext;
        y_init = -b_ext;
        z_init = (b_in >= 0) ? rpc_pkg::Z_HALF : -rpc_pkg::Z_HALF;
      end
    end else begin
      y_init = '0;
      z_init = z_pol;
      if (z_pol > rpc_pkg::Z_QUARTER) begin
        x_init = -a_ext;
        z_init = z_pol - rpc_pkg::Z_HALF;
      end else if (z_pol < -rpc_pkg::Z_QUARTER) begin
        x_init = -a_ext;
        z_init = z_pol + rpc_pkg::Z_HALF;
      end
    end
  end

  // Control of both stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1    <= '0;
      ctl_out <= '0;
    end else if (en) begin
      ctl1    <= ctl_init;
      ctl_out <= ctl1;
    end
  end

  // Payload of both stages; the second one adds the squares.
  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= a_in;
      b1    <= b_in;
      x1    <= x_init;
      y1    <= y_init;
      z1    <= z_init;
      sqa1  <= $unsigned(prod_a);
      sqb1  <= $unsigned(prod_b);
      a_out <= a1;
      b_out <= b1;
      x_out <= x1;
      y_out <= y1;
      z_out <= z1;
      v_out <= sqa1 + sqb1;
    end
  end

endmodule

FILE: hw/rtl/rpc_stage.sv
// One pipeline stage: a CORDIC micro-rotation and/or one integer square-root digit.
module rpc_stage #(
  parameter int DATA_WIDTH = 16,
  parameter int CORDIC_STAGES = 16,
  parameter int STAGE = 0,
  localparam int W = DATA_WIDTH + rpc_pkg::GUARD + rpc_pkg::DP_EXTRA,
  localparam int VW = 2 * DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  rpc_pkg::ctl_t                ctl_in,
  input  logic signed [DATA_WIDTH-1:0] a_in,
  input  logic signed [DATA_WIDTH-1:0] b_in,
  input  logic signed [W-1:0]          x_in,
  input  logic signed [W-1:0]          y_in,
  input  logic signed [rpc_pkg::Z_WIDTH-1:0] z_in,
  input  logic [VW-1:0]                v_in,
  input  logic [VW-1:0]                r_in,
  output rpc_pkg::ctl_t                ctl_out,
  output logic signed [DATA_WIDTH-1:0] a_out,
  output logic signed [DATA_WIDTH-1:0] b_out,
  output logic signed [W-1:0]          x_out,
  output logic signed [W-1:0]          y_out,
  output logic signed [rpc_pkg::Z_WIDTH-1:0] z_out,
  output logic [VW-1:0]                v_out,
  output logic [VW-1:0]                r_out
);

  localparam int ZW = rpc_pkg::Z_WIDTH;

  logic signed [W-1:0]  x_next;
  logic signed [W-1:0]  y_next;
  logic signed [ZW-1:0] z_next;
  logic [VW-1:0]        v_next;
  logic [VW-1:0]        r_next;

  // Micro-rotation; vectoring drives y toward zero, rotation drives z.
  if (STAGE < CORDIC_STAGES) begin : g_cordic
    localparam logic signed [ZW-1:0] ATAN = ZW'(rpc_pkg::ATAN_TURNS[STAGE]);
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic                ccw;
    assign dx  = y_in >>> STAGE;
    assign dy  = x_in >>> STAGE;
    assign ccw = ctl_in.rect ? (y_in < 0) : (z_in >= 0);
    always_comb begin
      if (ccw) begin
        x_next = x_in - dx;
        y_next = y_in + dy;
        z_next = z_in - ATAN;
      end else begin
        x_next = x_in + dx;
        y_next = y_in - dy;
        z_next = z_in + ATAN;
      end
    end
  end else begin : g_no_cordic
    assign x_next = x_in;
    assign y_next = y_in;
    assign z_next = z_in;
  end

  // Restoring square-root digit: subtract the trial value when it fits.
  if (STAGE < DATA_WIDTH) begin : g_root
    localparam logic [VW-1:0] DIGIT = VW'(1) << (2 * (DATA_WIDTH - 1 - STAGE));
    logic [VW-1:0] trial;
    assign trial = r_in + DIGIT;
    always_comb begin
      if (v_in >= trial) begin
        v_next = v_in - trial;
        r_next = (r_in >> 1) + DIGIT;
      end else begin
        v_next = v_in;
        r_next = r_in >> 1;
      end
    end
  end else begin : g_no_root
    assign v_next = v_in;
    assign r_next = r_in;
  end

  // Control register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (en) begin
      a_out <= a_in;
      b_out <= b_in;
      x_out <= x_next;
      y_out <= y_next;
      z_out <= z_next;
      v_out <= v_next;
      r_out <= r_next;
    end
  end

endmodule

FILE: hw/rtl/rpc_post.sv
// Output stages: gain scaling with rounding and saturation, length and angle rounding.
module rpc_post #(
  parameter int DATA_WIDTH = 16,
  parameter int CORDIC_STAGES = 16,
  localparam int W = DATA_WIDTH + rpc_pkg::GUARD + rpc_pkg::DP_EXTRA,
  localparam int VW = 2 * DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  rpc_pkg::ctl_t                ctl_in,
  input  logic signed [DATA_WIDTH-1:0] a_in,
  input  logic signed [DATA_WIDTH-1:0] b_in,
  input  logic signed [W-1:0]          x_in,
  input  logic signed [W-1:0]          y_in,
  input  logic signed [rpc_pkg::Z_WIDTH-1:0] z_in,
  input  logic [VW-1:0]                v_in,
  input  logic [VW-1:0]                r_in,
  output logic                         res_valid,
  output logic signed [DATA_WIDTH-1:0] x_res,
  output logic signed [DATA_WIDTH-1:0] y_res,
  output logic signed [DATA_WIDTH:0]   len_res,
  output logic signed [DATA_WIDTH-1:0] ang_res,
  output logic                         bad_res
);

  localparam int ZW  = rpc_pkg::Z_WIDTH;
  localparam int SH  = 32 - DATA_WIDTH;
  localparam int MHW = W - 32;
  localparam int TW  = MHW + 33;
  localparam int RW  = TW - rpc_pkg::GUARD;

  localparam logic [63:0] GAIN_ROOT = rpc_pkg::gain_root(CORDIC_STAGES);
  localparam logic [63:0] GAIN_FULL = ((64'd1 << 62) + (GAIN_ROOT >> 1)) / GAIN_ROOT;
  localparam logic [31:0] GAIN      = GAIN_FULL[31:0];

  localparam logic signed [ZW-1:0] ANG_ROUND = ZW'((64'd1 << SH) >> 1);
  localparam logic [TW-1:0] G_ROUND = TW'(1) << (rpc_pkg::GUARD - 1);
  localparam logic [RW-1:0] MAX_POS = RW'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
  localparam logic [RW-1:0] MAX_NEG = RW'(64'd1 << (DATA_WIDTH - 1));

  // Clip a magnitude to the signed output range and apply the sign.
  function automatic logic [DATA_WIDTH-1:0] sat_sign(input logic [RW-1:0] mag,
                                                     input logic neg);
    logic [RW-1:0] lim;
    logic [RW-1:0] clip;
    logic [RW-1:0] val;
    lim  = neg ? MAX_NEG : MAX_POS;
    clip = (mag > lim) ? lim : mag;
    val  = neg ? (~clip + 1'b1) : clip;
    return val[DATA_WIDTH-1:0];
  endfunction

  logic signed [ZW-1:0] z_round;
  logic [63:0]          prod_lx;
  logic [63:0]          prod_ly;

  rpc_pkg::ctl_t                ctl1, ctl2, ctl3;
  logic signed [DATA_WIDTH-1:0] a1, a2, a3;
  logic signed [DATA_WIDTH-1:0] b1, b2, b3;
  logic [DATA_WIDTH:0]          len1, len2, len3;
  logic [DATA_WIDTH-1:0]        ang1, ang2, ang3;
  logic                         negx1, negx2, negx3;
  logic                         negy1, negy2, negy3;
  logic [W-1:0]                 mx1;
  logic [W-1:0]                 my1;
  logic [MHW+31:0]              hx2;
  logic [MHW+31:0]              hy2;
  logic [31:0]                  lx2;
  logic [31:0]                  ly2;
  logic [TW-1:0]                tx3;
  logic [TW-1:0]                ty3;

  assign z_round = z_in + ANG_ROUND;
  assign prod_lx = mx1[31:0] * GAIN;
  assign prod_ly = my1[31:0] * GAIN;

  // Control of all four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1      <= '0;
      ctl2      <= '0;
      ctl3      <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      ctl1      <= ctl_in;
      ctl2      <= ctl1;
      ctl3      <= ctl2;
      res_valid <= ctl3.valid;
    end
  end

  // Magnitudes, rounded length and rounded angle.
  always_ff @(posedge clk) begin
    if (en) begin
      a1    <= a_in;
      b1    <= b_in;
      negx1 <= (x_in < 0);
      negy1 <= (y_in < 0);
      mx1   <= $unsigned((x_in < 0) ? -x_in : x_in);
      my1   <= $unsigned((y_in < 0) ? -y_in : y_in);
      len1  <= {1'b0, r_in[DATA_WIDTH-1:0]} + (DATA_WIDTH + 1)'(v_in > r_in);
      // The zero vector has angle zero.
      ang1  <= (a_in == 0 && b_in == 0) ? '0 : z_round[SH +: DATA_WIDTH];
    end
  end

  // Gain products: high word in full, low word keeps its upper half.
  always_ff @(posedge clk) begin
    if (en) begin
      a2    <= a1;
      b2    <= b1;
      len2  <= len1;
      ang2  <= ang1;
      negx2 <= negx1;
      negy2 <= negy1;
      hx2   <= mx1[W-1:32] * GAIN;
      hy2   <= my1[W-1:32] * GAIN;
      lx2   <= prod_lx[63:32];
      ly2   <= prod_ly[63:32];
    end
  end

  // Partial products combined with the rounding half added.
  always_ff @(posedge clk) begin
    if (en) begin
      a3    <= a2;
      b3    <= b2;
      len3  <= len2;
      ang3  <= ang2;
      negx3 <= negx2;
      negy3 <= negy2;
      tx3   <= TW'(hx2) + TW'(lx2) + G_ROUND;
      ty3   <= TW'(hy2) + TW'(ly2) + G_ROUND;
    end
  end

  // Saturation and selection of the result fields by mode.
  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl3.rect) begin
        x_res   <= a3;
        y_res   <= b3;
        len_res <= $signed(len3);
        ang_res <= $signed(ang3);
        bad_res <= 1'b0;
      end else if (ctl3.polar) begin
        x_res   <= $signed(sat_sign(tx3[TW-1:rpc_pkg::GUARD], negx3));
        y_res   <= $signed(sat_sign(ty3[TW-1:rpc_pkg::GUARD], negy3));
        len_res <= {a3[DATA_WIDTH-1], a3};
        ang_res <= b3;
        bad_res <= 1'b0;
      end else begin
        x_res   <= '0;
        y_res   <= '0;
        len_res <= '0;
        ang_res <= '0;
        bad_res <= 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/rect_polar_converter.sv
// Top level of the pipelined rectangular/polar vector converter.
//
// Requests arrive on the s_ channel: s_tuser is the mode (rectangular, polar,
// or invalid), s_tdata holds the two signed operands. Every accepted request
// gives exactly one result on the m_ channel: x, y, length and angle in m_tdata,
// and the invalid-mode flag in m_tuser. Angles are binary units where half of
// the angle range is a half turn.
// One request is accepted per cycle while s_tready is high. Between acceptance
// and m_tvalid lie the chain of CORDIC and square-root stages, two input
// stages (squares, start vector, sum), four output stages (magnitude, gain
// product, rounding add, saturation) and the output register.
// The result leaves through an output register backed by one skid register.
// While the receiver stalls, the pipeline keeps moving until the skid register
// fills; s_tready then drops until the receiver takes a result. Nothing is lost
// or repeated. Reset clears every valid bit; results in flight are dropped.
`include "rect_polar_converter_defines.svh"

module rect_polar_converter #(
  parameter int DATA_WIDTH = 16,
  parameter int CORDIC_STAGES = 16,
  localparam int IN_W = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_BITS = 4 * DATA_WIDTH + 1,
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // Fields from bit 0 up: first_operand, second_operand.
  input  logic [IN_W-1:0]  s_tdata,
  // Fields from bit 0 up: opcode.
  input  logic [1:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // Fields from bit 0 up: x_out, y_out, length_out, angle_out.
  output logic [OUT_W-1:0] m_tdata,
  // Fields from bit 0 up: bad_mode.
  output logic             m_tuser
);

  localparam int W  = DATA_WIDTH + rpc_pkg::GUARD + rpc_pkg::DP_EXTRA;
  localparam int VW = 2 * DATA_WIDTH;
  localparam int ZW = rpc_pkg::Z_WIDTH;
  localparam int NI = (CORDIC_STAGES > DATA_WIDTH) ? CORDIC_STAGES : DATA_WIDTH;

  logic en;
  logic skid_valid;
  logic out_take;

  rpc_pkg::ctl_t                st_ctl [NI+1];
  logic signed [DATA_WIDTH-1:0] st_a   [NI+1];
  logic signed [DATA_WIDTH-1:0] st_b   [NI+1];
  logic signed [W-1:0]          st_x   [NI+1];
  logic signed [W-1:0]          st_y   [NI+1];
  logic signed [ZW-1:0]         st_z   [NI+1];
  logic [VW-1:0]                st_v   [NI+1];
  logic [VW-1:0]                st_r   [NI+1];

  logic                         res_valid;
  logic signed [DATA_WIDTH-1:0] x_res;
  logic signed [DATA_WIDTH-1:0] y_res;
  logic signed [DATA_WIDTH:0]   len_res;
  logic signed [DATA_WIDTH-1:0] ang_res;
  logic                         bad_res;
  logic [OUT_BITS-1:0]          res_bits;

  logic [OUT_BITS-1:0]          out_bits;
  logic                         out_bad;
  logic [OUT_BITS-1:0]          skid_bits;
  logic                         skid_bad;

  // The whole pipeline advances unless the skid register holds a result.
  assign en       = !skid_valid;
  assign s_tready = en;
  assign out_take = !m_tvalid || m_tready;

  // Input stages.
  rpc_prep #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_prep (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(s_tvalid),
    .opcode  (s_tuser),
    .a_in    ($signed(s_tdata[DATA_WIDTH-1:0])),
    .b_in    ($signed(s_tdata[2*DATA_WIDTH-1:DATA_WIDTH])),
    .ctl_out (st_ctl[0]),
    .a_out   (st_a[0]),
    .b_out   (st_b[0]),
    .x_out   (st_x[0]),
    .y_out   (st_y[0]),
    .z_out   (st_z[0]),
    .v_out   (st_v[0])
  );

  // The square root starts with an empty root.
  assign st_r[0] = '0;

  // Chain of CORDIC and square-root stages.
  for (genvar k = 0; k < NI; k++) begin : g_stage
    rpc_stage #(
      .DATA_WIDTH   (DATA_WIDTH),
      .CORDIC_STAGES(CORDIC_STAGES),
      .STAGE        (k)
    ) u_stage (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctl_in (st_ctl[k]),
      .a_in   (st_a[k]),
      .b_in   (st_b[k]),
      .x_in   (st_x[k]),
      .y_in   (st_y[k]),
      .z_in   (st_z[k]),
      .v_in   (st_v[k]),
      .r_in   (st_r[k]),
      .ctl_out(st_ctl[k+1]),
      .a_out  (st_a[k+1]),
      .b_out  (st_b[k+1]),
      .x_out  (st_x[k+1]),
      .y_out  (st_y[k+1]),
      .z_out  (st_z[k+1]),
      .v_out  (st_v[k+1]),
      .r_out  (st_r[k+1])
    );
  end

  // Output stages.
  rpc_post #(
    .DATA_WIDTH   (DATA_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (st_ctl[NI]),
    .a_in     (st_a[NI]),
    .b_in     (st_b[NI]),
    .x_in     (st_x[NI]),
    .y_in     (st_y[NI]),
    .z_in     (st_z[NI]),
    .v_in     (st_v[NI]),
    .r_in     (st_r[NI]),
    .res_valid(res_valid),
    .x_res    (x_res),
    .y_res    (y_res),
    .len_res  (len_res),
    .ang_res  (ang_res),
    .bad_res  (bad_res)
  );

  assign res_bits = {ang_res, len_res, y_res, x_res};

  // Output and skid valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= res_valid;
      end
    end else if (res_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk) begin
    if (out_take) begin
      if (skid_valid) begin
        out_bits <= skid_bits;
        out_bad  <= skid_bad;
      end else begin
        out_bits <= res_bits;
        out_bad  <= bad_res;
      end
    end else if (!skid_valid) begin
      skid_bits <= res_bits;
      skid_bad  <= bad_res;
    end
  end

  assign m_tdata = OUT_W'(out_bits);
  assign m_tuser = out_bad;

  // A result waits in the skid register only behind a full output register.
  `RPC_ASSERT_HOLDS(a_skid_behind_out, skid_valid, m_tvalid,
                    "skid register holds a result while output is empty")
  // The skid register fills only from a stalled output.
  `RPC_ASSERT_HOLDS(a_skid_fill_on_stall, $rose(skid_valid),
                    $past(m_tvalid && !m_tready),
                    "skid register filled without a stalled output")
  // A taken output drains the skid register.
  `RPC_ASSERT_NEXT(a_skid_drains, skid_valid && m_tready, !skid_valid,
                   "skid register did not drain into a free output")
  // An invalid mode gives an all-zero result.
  `RPC_ASSERT_HOLDS(a_bad_mode_zero, m_tvalid && m_tuser, m_tdata == '0,
                    "invalid-mode result carries nonzero fields")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the rectangular/polar vector converter.
`timescale 1ns / 1ps

module tb;

  // Opcodes the block rejects.
  localparam logic [1:0] OP_INVALID_LO = 2'd2;
  localparam logic [1:0] OP_INVALID_HI = 2'd3;

  localparam int GUARD_BITS   = 24;
  localparam int STAGES       = 16;
  localparam longint HALF_TURN    = 64'sd1 <<< 31;
  localparam longint QUARTER_TURN = 64'sd1 <<< 30;

  localparam int RANDOM_PHASES   = 13;
  localparam int PHASE_ITEMS     = 100;
  localparam int SINK_HOLD       = 200;
  localparam int TAIL_CYCLES     = 40;
  localparam int CYCLE_LIMIT     = 200000;

  // One converted vector, fields in the order they sit on the result bus.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [16:0] len;
    logic signed [15:0] ang;
    logic               bad;
  } result_t;

  // One request, with an optional hand-written expectation.
  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] a;
    logic signed [15:0] b;
    bit                 typed;
    result_t            known;
  } request_t;

  localparam result_t ZERO_RESULT    = '0;
  localparam result_t INVALID_RESULT = {16'h0, 16'h0, 17'h0, 16'h0, 1'b1};
  localparam result_t HALF_TURN_ZERO = {16'h0, 16'h0, 17'h0, 16'h8000, 1'b0};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic        m_tuser;

  request_t directed_rows[$];
  request_t pending_q[$];
  result_t  expected_q[$];

  longint unsigned gain_k;
  bit steady_flow;
  bit hold_sink;
  int errors;
  int n_sent;
  int n_checked;
  int n_rect;
  int n_polar;
  int n_invalid;
  int cycle_count;

  rect_polar_converter #(
    .DATA_WIDTH(16),
    .CORDIC_STAGES(16)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Bitwise integer square root, truncating.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Applies the CORDIC gain to a coordinate, rounds half away from zero
  // and saturates to 16 bits.
  function automatic logic signed [15:0] scale_round(longint v);
    bit              neg;
    longint unsigned m;
    longint unsigned mh;
    longint unsigned ml;
    longint unsigned t;
    longint unsigned r;
    longint          res;
    neg = (v < 0);
    m = neg ? -v : v;
    mh = m >> 32;
    ml = m & 64'hFFFF_FFFF;
    t = mh * gain_k + ((ml * gain_k) >> 32);
    r = (t + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
    if (!neg && r > 32767) r = 32767;
    if (neg && r > 32768) r = 32768;
    res = neg ? -longint'(r) : longint'(r);
    return res[15:0];
  endfunction

  // Expected conversion of one request.
  function automatic result_t convert_vector(logic [1:0] op, logic signed [15:0] a,
                                             logic signed [15:0] b);
    result_t         res;
    longint          X;
    longint          Y;
    longint          Z;
    longint          dx;
    longint          dy;
    longint unsigned sq;
    longint unsigned root;
    res = '0;
    if (op == rpc_pkg::OP_RECT) begin
      // Length, rounded to nearest.
      sq = longint'(a) * longint'(a) + longint'(b) * longint'(b);
      root = int_sqrt(sq);
      if (sq - root * root > root) root++;
      // Angle by vectoring; the zero vector has angle zero.
      Z = 0;
      if (a != 0 || b != 0) begin
        X = longint'(a) <<< GUARD_BITS;
        Y = longint'(b) <<< GUARD_BITS;
        if (X < 0) begin
          X = -X;
          Y = -Y;
          Z = (b >= 0) ? HALF_TURN : -HALF_TURN;
        end
        for (int i = 0; i < STAGES; i++) begin
          dx = Y >>> i;
          dy = X >>> i;
          if (Y < 0) begin
            X -= dx;
            Y += dy;
            Z -= longint'(rpc_pkg::ATAN_TURNS[i]);
          end else begin
            X += dx;
            Y -= dy;
            Z += longint'(rpc_pkg::ATAN_TURNS[i]);
          end
        end
      end
      Z = (Z + (64'sd1 <<< 15)) >>> 16;
      res.x = a;
      res.y = b;
      res.len = root[16:0];
      res.ang = Z[15:0];
    end else if (op == rpc_pkg::OP_POLAR) begin
      // Rotation, folding angles beyond a quarter turn by a half turn.
      X = longint'(a) <<< GUARD_BITS;
      Y = 0;
      Z = longint'(b) <<< 16;
      if (Z > QUARTER_TURN) begin
        X = -X;
        Z -= HALF_TURN;
      end else if (Z < -QUARTER_TURN) begin
        X = -X;
        Z += HALF_TURN;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = Y >>> i;
        dy = X >>> i;
        if (Z >= 0) begin
          X -= dx;
          Y += dy;
          Z -= longint'(rpc_pkg::ATAN_TURNS[i]);
        end else begin
          X += dx;
          Y -= dy;
          Z += longint'(rpc_pkg::ATAN_TURNS[i]);
        end
      end
      res.x = scale_round(X);
      res.y = scale_round(Y);
      res.len = {a[15], a};
      res.ang = b;
    end else begin
      res.bad = 1'b1;
    end
    return res;
  endfunction

  // Text form of one result for reports.
  function automatic string describe(result_t r);
    return $sformatf("x=%0d y=%0d len=%0d ang=%0d bad=%0b",
                     r.x, r.y, r.len, r.ang, r.bad);
  endfunction

  // Random operand, weighted toward extremes, small values and quarter turns.
  function automatic logic signed [15:0] random_operand();
    logic signed [15:0] v;
    case ($urandom_range(0, 9)) inside
      0: begin
        case ($urandom_range(0, 4))
          0: v = -16'sd32768;
          1: v = 16'sd32767;
          2: v = 16'sd0;
          3: v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      [1:2]: v = 16'(int'($urandom_range(0, 64)) - 32);
      3: v = 16'(($urandom_range(0, 1) ? 16384 : -16384)
                 + int'($urandom_range(0, 4)) - 2);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic void add_row(logic [1:0] op, logic signed [15:0] a,
                                  logic signed [15:0] b, bit typed = 1'b0,
                                  result_t known = '0);
    request_t r;
    r.op = op;
    r.a = a;
    r.b = b;
    r.typed = typed;
    r.known = known;
    directed_rows.push_back(r);
  endfunction

  // Offers one request, after a random gap unless the flow is steady, and waits until it is taken.
  task automatic offer_request(request_t r);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 6);
    pending_q.push_back(r);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.op;
    s_tdata <= {r.b, r.a};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    n_sent++;
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0 || expected_q.size() != 0) @(negedge clk);
  endtask

  // CORDIC gain constant in Q32.
  initial begin : gain_setup
    longint unsigned p;
    longint unsigned s;
    p = 64'd1 << 60;
    for (int i = 0; i < STAGES; i++) p += p >> (2 * i);
    s = int_sqrt(p);
    gain_k = ((64'd1 << 62) + (s >> 1)) / s;
  end

  // Result receiver with random stalls and one long hold-off on request.
  initial begin : sink
    int wait_cycles;
    m_tready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (SINK_HOLD) @(negedge clk);
        hold_sink = 1'b0;
      end
      wait_cycles = steady_flow ? 0 : $urandom_range(0, 6);
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Records accepted requests and checks every accepted result in order.
  always @(posedge clk) begin : monitor
    request_t req;
    result_t  want;
    result_t  got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        req = pending_q.pop_front();
        if (req.typed) begin
          want = req.known;
        end else begin
          want = convert_vector(s_tuser, s_tdata[15:0], s_tdata[31:16]);
        end
        expected_q.push_back(want);
        if (s_tuser == rpc_pkg::OP_RECT) n_rect++;
        else if (s_tuser == rpc_pkg::OP_POLAR) n_polar++;
        else n_invalid++;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[31:16], m_tdata[48:32], m_tdata[64:49], m_tuser};
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %s", $time, describe(got));
        end else begin
          want = expected_q.pop_front();
          n_checked++;
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch: expected %s, got %s",
                     $time, describe(want), describe(got));
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin : stimulus
    request_t r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = rpc_pkg::OP_RECT;
    steady_flow = 1'b0;
    hold_sink = 1'b0;
    errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_rect = 0;
    n_polar = 0;
    n_invalid = 0;
    cycle_count = 0;

    // Invalid modes, zero vectors and the field extremes.
    add_row(OP_INVALID_LO, -32768, 32767, 1'b1, INVALID_RESULT);
    add_row(OP_INVALID_HI, -1, -1, 1'b1, INVALID_RESULT);
    add_row(OP_INVALID_LO, 0, 0, 1'b1, INVALID_RESULT);
    add_row(rpc_pkg::OP_RECT, 0, 0, 1'b1, ZERO_RESULT);
    add_row(rpc_pkg::OP_RECT, 32767, 32767);
    add_row(rpc_pkg::OP_RECT, -32768, -32768);
    add_row(rpc_pkg::OP_RECT, -32768, 0);
    add_row(rpc_pkg::OP_RECT, -1, 0);
    add_row(rpc_pkg::OP_RECT, -5, -1);
    add_row(rpc_pkg::OP_RECT, 0, 32767);
    add_row(rpc_pkg::OP_RECT, 0, -32768);
    add_row(rpc_pkg::OP_RECT, 1, 1);
    add_row(rpc_pkg::OP_RECT, 32767, -32768);
    add_row(rpc_pkg::OP_POLAR, 0, 0, 1'b1, ZERO_RESULT);
    add_row(rpc_pkg::OP_POLAR, 0, -32768, 1'b1, HALF_TURN_ZERO);
    add_row(rpc_pkg::OP_POLAR, 32767, 0);
    add_row(rpc_pkg::OP_POLAR, 32767, 16384);
    add_row(rpc_pkg::OP_POLAR, 32767, 16385);
    add_row(rpc_pkg::OP_POLAR, 32767, -16385);
    add_row(rpc_pkg::OP_POLAR, 32767, -32768);
    add_row(rpc_pkg::OP_POLAR, -32768, 8192);
    add_row(rpc_pkg::OP_POLAR, -32768, -32768);
    add_row(rpc_pkg::OP_POLAR, 32767, 32767);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) offer_request(directed_rows[i]);
    drain_results();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // The first phase streams into a stalled receiver so the pipe backs up.
      steady_flow = (phase == 0) || ($urandom_range(0, 3) == 0);
      if (phase == 0) hold_sink = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 19)) inside
          [0:8]:   r.op = rpc_pkg::OP_RECT;
          [9:17]:  r.op = rpc_pkg::OP_POLAR;
          18:      r.op = OP_INVALID_LO;
          default: r.op = OP_INVALID_HI;
        endcase
        r.a = random_operand();
        r.b = random_operand();
        r.typed = 1'b0;
        r.known = '0;
        offer_request(r);
      end
      // Every other phase the sender waits for the pipe to empty.
      if (phase % 2 == 1) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d requests (%0d rectangular, %0d polar, %0d invalid mode).",
             n_sent, n_rect, n_polar, n_invalid);
    $display("Checked %0d results with %0d mismatches.", n_checked, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rpc_pkg.sv
hw/rtl/rpc_prep.sv
hw/rtl/rpc_stage.sv
hw/rtl/rpc_post.sv
hw/rtl/rect_polar_converter.sv
tb/tb.sv
